// ----- src/pvc_pkg.sv -----
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, sizes and codes of the polygon vertex collector.
// ----------------------------------------------------------------------------
package pvc_pkg;

    localparam int MAX_VERTS  = 64;
    localparam int COORD_BITS = 26;
    localparam int IDX_BITS   = $clog2(MAX_VERTS);
    localparam int CNT_BITS   = 7;
    localparam int STEP_BITS  = 7;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_OOB     = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_DUP   = 2'd1;
    localparam logic [1:0] REG_PLANE = 2'd2;

    localparam logic [24:0] LIMIT_RST = 25'd25600000;
    localparam logic [19:0] DUP_RST   = 20'd656;
    localparam logic [15:0] PLANE_RST = 16'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vtx;

    // Sign class of a cross product
    typedef enum logic [1:0] {
        SG_ZERO = 2'd0,
        SG_POS  = 2'd1,
        SG_NEG  = 2'd2
    } t_sign;

    // True when -lim <= c <= lim
    function automatic logic in_bounds(input t_coord c, input logic [24:0] lim);
        logic signed [COORD_BITS:0] w;
        logic signed [COORD_BITS:0] l;
        w = {c[COORD_BITS-1], c};
        l = $signed({{(COORD_BITS+1-25){1'b0}}, lim});
        return (w <= l) && (w >= -l);
    endfunction

endpackage

// ----- src/pvc_cell.sv -----
// ----------------------------------------------------------------------------
// pvc_cell
// One vertex slot of the rotating store ring.
// ----------------------------------------------------------------------------
module pvc_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_load,
    input  pvc_pkg::t_vtx i_next,
    input  pvc_pkg::t_vtx i_load_vtx,
    output pvc_pkg::t_vtx o_vtx
);

    pvc_pkg::t_vtx r_vtx;

    // Load a new vertex, or take the neighbor's while rotating
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vtx <= i_load_vtx;
        end else if (i_shift) begin
            r_vtx <= i_next;
        end
    end

    assign o_vtx = r_vtx;

endmodule

// ----- src/pvc_dup_unit.sv -----
// ----------------------------------------------------------------------------
// pvc_dup_unit
// Three-stage squared-distance check of stored vertices against a new one.
// ----------------------------------------------------------------------------
module pvc_dup_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_feed,
    input  pvc_pkg::t_vtx i_vtx,
    input  pvc_pkg::t_vtx i_ref,
    input  logic [19:0]   i_dup_dist_sq,
    output logic          o_dup
);

    localparam int CB = pvc_pkg::COORD_BITS;

    logic            r_d_v, r_m_v, r_dup;
    logic [CB-1:0]   r_dx, r_dy, r_dz;
    logic [2*CB-1:0] r_sx, r_sy, r_sz;

    function automatic logic [CB-1:0] absdiff(input pvc_pkg::t_coord a,
                                              input pvc_pkg::t_coord b);
        logic signed [CB:0] d;
        d = {a[CB-1], a} - {b[CB-1], b};
        return d[CB] ? CB'(-d) : d[CB-1:0];
    endfunction

    // Pipeline valids and the sticky duplicate flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_m_v <= 1'b0;
            r_dup <= 1'b0;
        end else begin
            r_d_v <= i_feed;
            r_m_v <= r_d_v;
            if (i_start) begin
                r_dup <= 1'b0;
            end else if (r_m_v &&
                         ((CB*2+2)'(r_sx) + (CB*2+2)'(r_sy) + (CB*2+2)'(r_sz)
                          < (CB*2+2)'(i_dup_dist_sq))) begin
                r_dup <= 1'b1;
            end
        end
    end

    // Differences, then squares
    always_ff @(posedge i_clk) begin
        r_dx <= absdiff(i_vtx.x, i_ref.x);
        r_dy <= absdiff(i_vtx.y, i_ref.y);
        r_dz <= absdiff(i_vtx.z, i_ref.z);
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
        r_sz <= r_dz * r_dz;
    end

    assign o_dup = r_dup;

endmodule

// ----- src/pvc_cvx_unit.sv -----
// ----------------------------------------------------------------------------
// pvc_cvx_unit
// Plane and wrap-around cross product sign check over a vertex stream.
// ----------------------------------------------------------------------------
module pvc_cvx_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_feed,
    input  pvc_pkg::t_vtx i_vtx,
    input  logic [15:0]   i_plane_tol,
    output logic          o_bad
);

    localparam int CB = pvc_pkg::COORD_BITS;

    logic [1:0]                 r_fed;
    logic                       r_d_v, r_m_v, r_bad;
    pvc_pkg::t_sign             r_last;
    pvc_pkg::t_sign             n_sign;
    pvc_pkg::t_coord            r_z0, r_w1x, r_w1y, r_w2x, r_w2y;
    logic signed [CB:0]         r_v1x, r_v1y, r_v2x, r_v2y, zd;
    logic signed [2*CB+1:0]     r_p1, r_p2;
    logic [CB:0]                zabs;

    always_comb begin
        zd   = {i_vtx.z[CB-1], i_vtx.z} - {r_z0[CB-1], r_z0};
        zabs = zd[CB] ? -zd : zd;
        if (r_p1 > r_p2) begin
            n_sign = pvc_pkg::SG_POS;
        end else if (r_p1 < r_p2) begin
            n_sign = pvc_pkg::SG_NEG;
        end else begin
            n_sign = pvc_pkg::SG_ZERO;
        end
    end

    // Control: fill count, stage valids, sign history, fail flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fed  <= 2'd0;
            r_d_v  <= 1'b0;
            r_m_v  <= 1'b0;
            r_bad  <= 1'b0;
            r_last <= pvc_pkg::SG_ZERO;
        end else if (i_start) begin
            r_fed  <= 2'd0;
            r_d_v  <= 1'b0;
            r_m_v  <= 1'b0;
            r_bad  <= 1'b0;
            r_last <= pvc_pkg::SG_ZERO;
        end else begin
            r_d_v <= i_feed && (r_fed == 2'd2);
            r_m_v <= r_d_v;
            if (i_feed) begin
                if (r_fed != 2'd2) begin
                    r_fed <= r_fed + 2'd1;
                end
                if (r_fed != 2'd0 && zabs > (CB+1)'(i_plane_tol)) begin
                    r_bad <= 1'b1;
                end
            end
            if (r_m_v) begin
                r_last <= n_sign;
                if ((r_last == pvc_pkg::SG_POS && n_sign == pvc_pkg::SG_NEG) ||
                    (r_last == pvc_pkg::SG_NEG && n_sign == pvc_pkg::SG_POS)) begin
                    r_bad <= 1'b1;
                end
            end
        end
    end

    // Window of the two previous points, edge vectors, products
    always_ff @(posedge i_clk) begin
        if (i_feed) begin
            if (r_fed == 2'd0) begin
                r_z0 <= i_vtx.z;
            end
            r_w2x <= r_w1x;
            r_w2y <= r_w1y;
            r_w1x <= i_vtx.x;
            r_w1y <= i_vtx.y;
        end
        r_v1x <= {r_w1x[CB-1], r_w1x} - {r_w2x[CB-1], r_w2x};
        r_v1y <= {r_w1y[CB-1], r_w1y} - {r_w2y[CB-1], r_w2y};
        r_v2x <= {i_vtx.x[CB-1], i_vtx.x} - {r_w1x[CB-1], r_w1x};
        r_v2y <= {i_vtx.y[CB-1], i_vtx.y} - {r_w1y[CB-1], r_w1y};
        r_p1  <= r_v1x * r_v2y;
        r_p2  <= r_v1y * r_v2x;
    end

    assign o_bad = r_bad;

endmodule

// ----- src/polygon_vertex_collect_convexity.sv -----
// ----------------------------------------------------------------------------
// polygon_vertex_collect_convexity
// Vertex store with bounds, duplicate, planarity and convexity checks.
// ----------------------------------------------------------------------------
// One item at a time. A clear goes from its accept straight to the output
// step. An add walks the store once for the duplicate check, done by the
// rotating ring of vertex cells feeding one distance unit, then a decision
// step, and then, whether appended or rejected, walks it once more for the
// plane and convexity check and the output step. An out-of-bounds add skips
// the duplicate walk. A result is held in an output register while the next
// item is taken; a result still waiting there holds the next one in its
// last cycle.
module polygon_vertex_collect_convexity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // pos_x[25:0], pos_y[51:26], pos_z[77:52]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[2:0], vertex_count[9:3], poly_valid[10]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MV = pvc_pkg::MAX_VERTS;
    localparam int CB = pvc_pkg::COORD_BITS;
    localparam int SB = pvc_pkg::STEP_BITS;
    localparam int NB = pvc_pkg::CNT_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DUP    = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_VAL    = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]      r_state;
    logic [SB-1:0]   r_t;
    logic [NB-1:0]   r_count;
    logic [2:0]      r_status;
    logic            r_valid, r_out_valid;
    logic [15:0]     r_out;
    logic [24:0]     r_limit;
    logic [19:0]     r_dup_sq;
    logic [15:0]     r_plane;
    pvc_pkg::t_vtx   r_new, r_p0, r_p1, in_vtx, cvx_vtx;
    pvc_pkg::t_vtx   cells [MV];
    logic            accept, shift, load, dup, bad, dup_feed, cvx_feed, cvx_start;
    logic            oob;
    logic [1:0]      widx;

    assign in_vtx.x = s_axis_tdata[CB-1:0];
    assign in_vtx.y = s_axis_tdata[2*CB-1:CB];
    assign in_vtx.z = s_axis_tdata[3*CB-1:2*CB];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign oob = !pvc_pkg::in_bounds(in_vtx.x, r_limit) ||
                 !pvc_pkg::in_bounds(in_vtx.y, r_limit) ||
                 !pvc_pkg::in_bounds(in_vtx.z, r_limit);

    assign shift     = (r_state == S_DUP || r_state == S_VAL) && (r_t < SB'(MV));
    assign load      = (r_state == S_DECIDE) && !dup && (r_count != NB'(MV));
    assign dup_feed  = (r_state == S_DUP) && (r_t < SB'(r_count));
    assign cvx_start = accept;
    assign cvx_feed  = (r_state == S_VAL) &&
                       ((r_t < SB'(r_count)) || r_t == SB'(MV) || r_t == SB'(MV + 1));
    assign cvx_vtx   = (r_t == SB'(MV)) ? r_p0 :
                       (r_t == SB'(MV + 1)) ? r_p1 : cells[0];

    // Ring of vertex cells; head is cell 0
    genvar k;
    generate
        for (k = 0; k < MV; k++) begin : g_cell
            pvc_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (shift),
                .i_load     (load && (r_count[pvc_pkg::IDX_BITS-1:0] ==
                                      pvc_pkg::IDX_BITS'(k))),
                .i_next     (cells[(k + 1) % MV]),
                .i_load_vtx (r_new),
                .o_vtx      (cells[k])
            );
        end
    endgenerate

    pvc_dup_unit u_dup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_feed        (dup_feed),
        .i_vtx         (cells[0]),
        .i_ref         (r_new),
        .i_dup_dist_sq (r_dup_sq),
        .o_dup         (dup)
    );

    pvc_cvx_unit u_cvx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cvx_start),
        .i_feed      (cvx_feed),
        .i_vtx       (cvx_vtx),
        .i_plane_tol (r_plane),
        .o_bad       (bad)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_t <= '0;
                        if (s_axis_tuser) begin
                            r_count  <= '0;
                            r_valid  <= 1'b0;
                            r_status <= pvc_pkg::ST_CLEARED;
                            r_state  <= S_FIN;
                        end else if (oob) begin
                            r_status <= pvc_pkg::ST_OOB;
                            r_state  <= S_VAL;
                        end else begin
                            r_state <= S_DUP;
                        end
                    end
                end
                S_DUP: begin
                    r_t <= r_t + SB'(1);
                    if (r_t == SB'(MV + 3)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_t     <= '0;
                    r_state <= S_VAL;
                    if (dup) begin
                        r_status <= pvc_pkg::ST_DUP;
                    end else if (r_count == NB'(MV)) begin
                        r_status <= pvc_pkg::ST_FULL;
                    end else begin
                        r_status <= pvc_pkg::ST_ADDED;
                        r_count  <= r_count + NB'(1);
                    end
                end
                S_VAL: begin
                    r_t <= r_t + SB'(1);
                    if (r_t == SB'(MV + 5)) begin
                        r_valid <= (r_count >= NB'(3)) && !bad;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Capture the new vertex and the first two points of the walk
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new <= in_vtx;
        end
        if (r_state == S_VAL && r_t == SB'(0)) begin
            r_p0 <= cells[0];
        end
        if (r_state == S_VAL && r_t == SB'(1)) begin
            r_p1 <= cells[0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_out_valid || m_axis_tready)) begin
            r_out <= {5'd0, r_valid, r_count, r_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Configuration registers
    assign widx   = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= pvc_pkg::LIMIT_RST;
            r_dup_sq <= pvc_pkg::DUP_RST;
            r_plane  <= pvc_pkg::PLANE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                pvc_pkg::REG_LIMIT: r_limit  <= pwdata[24:0];
                pvc_pkg::REG_DUP:   r_dup_sq <= pwdata[19:0];
                pvc_pkg::REG_PLANE: r_plane  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            pvc_pkg::REG_LIMIT: prdata = {7'd0, r_limit};
            pvc_pkg::REG_DUP:   prdata = {12'd0, r_dup_sq};
            pvc_pkg::REG_PLANE: prdata = {16'd0, r_plane};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polygon vertex collector: directed and random add
// and clear transfers with random back-pressure, checked against a behavioral model.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct {
        logic        mode;
        logic [25:0] px;
        logic [25:0] py;
        logic [25:0] pz;
    } t_cmd;

    typedef struct {
        logic [2:0] status;
        logic [6:0] count;
        logic       valid;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;   // pos_x[25:0], pos_y[51:26], pos_z[77:52]
    logic        s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // status[2:0], vertex_count[9:3], poly_valid[10]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    polygon_vertex_collect_convexity u_dut (.*);

    // Model state
    longint      vx [pvc_pkg::MAX_VERTS];
    longint      vy [pvc_pkg::MAX_VERTS];
    longint      vz [pvc_pkg::MAX_VERTS];
    int          nverts;
    longint      lim_reg;
    longint      dup_reg;
    longint      tol_reg;

    t_cmd        cmd_q [$];
    t_res        result_q [$];
    int          src_idle_pct;
    int          snk_idle_pct;
    int          watchdog;
    int          errors;
    logic        in_done;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic longint sx(logic [25:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint absd(longint a, longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic bit poly_ok();
        longint prev, cr, ax, ay, bx, by;
        int     a, b;
        prev = 0;
        if (nverts < 3) return 1'b0;
        for (int i = 1; i < nverts; i++)
            if (absd(vz[i], vz[0]) > tol_reg) return 1'b0;
        for (int i = 0; i < nverts; i++) begin
            a  = (i + 1) % nverts;
            b  = (i + 2) % nverts;
            ax = vx[a] - vx[i];
            ay = vy[a] - vy[i];
            bx = vx[b] - vx[a];
            by = vy[b] - vy[a];
            cr = ax * by - ay * bx;
            if (i > 0 && ((prev > 0 && cr < 0) || (prev < 0 && cr > 0))) return 1'b0;
            prev = cr;
        end
        return 1'b1;
    endfunction

    // Apply one transfer to the model and queue its result
    function automatic void collect_vertex(t_cmd c);
        t_res   r;
        longint x, y, z, dx, dy, dz;
        x = sx(c.px);
        y = sx(c.py);
        z = sx(c.pz);
        r.status = pvc_pkg::ST_ADDED;
        if (c.mode) begin
            nverts   = 0;
            r.status = pvc_pkg::ST_CLEARED;
        end else if (x < -lim_reg || x > lim_reg || y < -lim_reg || y > lim_reg ||
                     z < -lim_reg || z > lim_reg) begin
            r.status = pvc_pkg::ST_OOB;
        end else begin
            for (int i = 0; i < nverts; i++) begin
                dx = absd(vx[i], x);
                dy = absd(vy[i], y);
                dz = absd(vz[i], z);
                if (dx * dx + dy * dy + dz * dz < dup_reg) begin
                    r.status = pvc_pkg::ST_DUP;
                    break;
                end
            end
            if (r.status == pvc_pkg::ST_ADDED) begin
                if (nverts >= pvc_pkg::MAX_VERTS) begin
                    r.status = pvc_pkg::ST_FULL;
                end else begin
                    vx[nverts] = x;
                    vy[nverts] = y;
                    vz[nverts] = z;
                    nverts++;
                end
            end
        end
        r.count = 7'(nverts);
        r.valid = poly_ok();
        result_q.push_back(r);
    endfunction

    // Driver: present queued transfers at the falling edge once the last one is taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_done) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cmd_q[0].mode;
                    s_axis_tdata  <= {2'b0, cmd_q[0].pz, cmd_q[0].py, cmd_q[0].px};
                    void'(cmd_q.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_cmd c;
        t_res e;
        in_done <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                watchdog <= 0;
            end else begin
                watchdog <= watchdog + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                c.mode = s_axis_tuser;
                c.px   = s_axis_tdata[25:0];
                c.py   = s_axis_tdata[51:26];
                c.pz   = s_axis_tdata[77:52];
                collect_vertex(c);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    e = result_q.pop_front();
                    if (m_axis_tdata[2:0] !== e.status || m_axis_tdata[9:3] !== e.count ||
                        m_axis_tdata[10] !== e.valid) begin
                        $display("%0t: expected status %0d count %0d valid %0d, got %0d %0d %0d",
                                 $time, e.status, e.count, e.valid, m_axis_tdata[2:0],
                                 m_axis_tdata[9:3], m_axis_tdata[10]);
                        errors++;
                    end
                end
            end
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pvc_pkg::REG_LIMIT: lim_reg = val & 32'h1FFFFFF;
            pvc_pkg::REG_DUP:   dup_reg = val & 32'hFFFFF;
            default:            tol_reg = val & 32'hFFFF;
        endcase
    endtask

    task automatic push_vertex(logic m, longint x, longint y, longint z);
        t_cmd c;
        c.mode = m;
        c.px   = 26'(x);
        c.py   = 26'(y);
        c.pz   = 26'(z);
        cmd_q.push_back(c);
    endtask

    // Wait for all results, then a quiet gap for the block to settle
    task automatic drain();
        wait (cmd_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        longint b, cx, cy, r;
        int     k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 4) begin
                push_vertex(1'b1, $urandom, $urandom, $urandom);
            end else if (k < 14) begin
                // raw noise, often out of bounds
                push_vertex(1'b0, $urandom, $urandom, $urandom);
            end else if (k < 60) begin
                // random points in a box beside a random center, small z spread
                b  = (lim_reg > 4000) ? 2000 : lim_reg / 2;
                cx = longint'($urandom_range(2 * b)) - b;
                cy = longint'($urandom_range(2 * b)) - b;
                r  = $urandom_range(20, 1000);
                push_vertex(1'b0, cx + $urandom_range(r), cy - r + $urandom_range(2 * r),
                            $urandom_range(3));
            end else if (k < 70) begin
                // near-duplicate of a small grid
                push_vertex(1'b0, $urandom_range(3) * 40, $urandom_range(3) * 40,
                            $urandom_range(2));
            end else if (k < 80) begin
                // edge of the bounds
                push_vertex(1'b0, $urandom_range(1) ? lim_reg : -lim_reg,
                            ($urandom_range(1) ? lim_reg + 1 : lim_reg - $urandom_range(5)),
                            $urandom_range(100));
            end else begin
                push_vertex(1'b0, longint'($urandom_range(20000)) - 10000,
                            longint'($urandom_range(20000)) - 10000,
                            longint'($urandom_range(6)) - 3);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_done       = 1'b0;
        nverts        = 0;
        lim_reg       = pvc_pkg::LIMIT_RST;
        dup_reg       = pvc_pkg::DUP_RST;
        tol_reg       = pvc_pkg::PLANE_RST;
        watchdog      = 0;
        errors        = 0;
        src_idle_pct  = 27;
        snk_idle_pct  = 46;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: square, collinear points, non-planar, bounds, clear
        push_vertex(1'b0, 0, 0, 0);
        push_vertex(1'b0, 1000, 0, 0);
        push_vertex(1'b0, 1000, 1000, 1);
        push_vertex(1'b0, 0, 1000, 2);
        push_vertex(1'b0, 10, 10, 0);
        push_vertex(1'b0, 500, 500, 0);
        push_vertex(1'b0, 2000, 0, 0);
        push_vertex(1'b0, 25600000, -25600000, 0);
        push_vertex(1'b0, 25600001, 0, 0);
        push_vertex(1'b0, 0, -25600001, 0);
        push_vertex(1'b0, 0, 0, 33554431);
        push_vertex(1'b0, -33554432, 0, 0);
        push_vertex(1'b1, 26'h3FFFFFF, 26'h3FFFFFF, 26'h3FFFFFF);
        push_vertex(1'b0, 0, 0, 0);
        push_vertex(1'b0, 100, 0, 0);
        push_vertex(1'b0, 200, 0, 0);
        push_vertex(1'b0, 300, 0, 5);
        push_vertex(1'b1, 0, 0, 0);
        drain();

        // Fill the store to capacity and overflow it
        reg_write(pvc_pkg::REG_DUP, 0);
        for (int i = 0; i < pvc_pkg::MAX_VERTS + 3; i++) push_vertex(1'b0, i, i * i, 0);
        push_vertex(1'b0, 0, 0, 0);
        push_vertex(1'b1, 0, 0, 0);
        drain();

        reg_write(pvc_pkg::REG_LIMIT, 25'h1FFFFFF);
        reg_write(pvc_pkg::REG_DUP, 20'hFFFFF);
        reg_write(pvc_pkg::REG_PLANE, 16'hFFFF);
        random_phase(150);
        drain();

        reg_write(pvc_pkg::REG_LIMIT, 3000);
        reg_write(pvc_pkg::REG_DUP, 900);
        reg_write(pvc_pkg::REG_PLANE, 0);
        random_phase(150);
        drain();

        src_idle_pct = 46;
        snk_idle_pct = 27;
        reg_write(pvc_pkg::REG_LIMIT, 0);
        reg_write(pvc_pkg::REG_DUP, 1);
        random_phase(60);
        drain();

        reg_write(pvc_pkg::REG_LIMIT, 25600000);
        reg_write(pvc_pkg::REG_DUP, 656);
        reg_write(pvc_pkg::REG_PLANE, 2);
        random_phase(240);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        reg_write(pvc_pkg::REG_DUP, 40000);
        reg_write(pvc_pkg::REG_PLANE, 3);
        random_phase(250);
        drain();

        if (errors == 0 && result_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
